// ===== sv/cc20_pkg.sv =====
// Shared types and constants for the ChaCha20 stream XOR block.
// No dependencies; every other file imports this package.
package cc20_pkg;

    localparam int DATA_W     = 64;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int RND_W      = 5;

    localparam logic [CNT_W-1:0] FULL_COUNT = 4'd8;

    // 20 rounds, one column or diagonal round per cycle
    localparam logic [RND_W-1:0] LAST_ROUND = 5'd19;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR   = 3'd6;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic accept;   // capture request, settle counter and position
        logic load;     // load working state from the input block
        logic round;    // apply one round to the working state
        logic diag;     // diagonal round when set, column round otherwise
        logic add;      // feed-forward add into keystream
        logic emit;     // write result register
    } cmd_t;

    typedef struct packed {
        logic need_block;
        logic out_free;
    } status_t;

endpackage

// ===== sv/cc20_if.sv =====
// Request channel interfaces: message items in, result items out.
// Depends on cc20_pkg for payload widths.
interface cc20_in_if import cc20_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_in;
    logic [CNT_W-1:0]  byte_count;
    logic              first_of_message;
    logic              last_of_message;

    modport source (output valid, output data_in, output byte_count,
                    output first_of_message, output last_of_message, input ready);
    modport sink   (input valid, input data_in, input byte_count,
                    input first_of_message, input last_of_message, output ready);
endinterface

interface cc20_out_if import cc20_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  byte_count_out;
    logic              last_out;

    modport source (output valid, output data_out, output byte_count_out,
                    output last_out, input ready);
    modport sink   (input valid, input data_out, input byte_count_out,
                     input last_out, output ready);
endinterface

// ===== sv/cc20_ctrl.sv =====
// Sequencer for the ChaCha20 stream block: accept, rounds, feed-forward, emit.
// Depends on cc20_pkg; drives cc20_datapath through cmd_t.
module cc20_ctrl import cc20_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.diag   = rnd_reg[0];
        unique case (state_reg)
            ST_IDLE:
            begin
                rnd_next = '0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.need_block)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_ADD;
                else
                    rnd_next = rnd_reg + 1'b1;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

// ===== sv/cc20_datapath.sv =====
// Datapath: key/nonce registers, round state, keystream, counter and result register.
// Depends on cc20_pkg; commanded by cc20_ctrl.
module cc20_datapath import cc20_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [DATA_W-1:0]     data_in,
    input  logic [CNT_W-1:0]      byte_count,
    input  logic                  first_of_message,
    input  logic                  last_of_message,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     data_out,
    output logic [CNT_W-1:0]      byte_count_out,
    output logic                  last_out
);

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic quad_t qround(input word_t a, input word_t b,
                                     input word_t c, input word_t d);
        quad_t q;
        q.a = a + b;   q.d = rotl(d ^ q.a, 16);
        q.c = c + q.d; q.b = rotl(b ^ q.c, 12);
        q.a = q.a + q.b; q.d = rotl(q.d ^ q.a, 8);
        q.c = q.c + q.d; q.b = rotl(q.b ^ q.c, 7);
        qround = q;
    endfunction

    logic [DATA_W-1:0] key_reg [4];
    logic [63:0]       nonce_low_reg;
    logic [31:0]       nonce_high_reg;
    logic [31:0]       init_ctr_reg;

    word_t             work_reg [16];
    word_t             work_rnd [16];
    logic [63:0]       ks_reg [8];
    logic [31:0]       ctr_reg;
    logic [2:0]        pos_reg;

    logic [DATA_W-1:0] item_data_reg;
    logic [CNT_W-1:0]  item_cnt_reg;
    logic              item_last_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_last_reg;

    logic [31:0]       ctr_eff;
    logic [2:0]        pos_eff;
    word_t             init_eff [16];
    word_t             init_cur [16];
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] ks_word;

    assign ctr_eff = first_of_message ? init_ctr_reg : ctr_reg;
    assign pos_eff = first_of_message ? 3'd0 : pos_reg;

    assign status.need_block = (pos_eff == 3'd0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        init_eff[0] = SIGMA0;
        init_eff[1] = SIGMA1;
        init_eff[2] = SIGMA2;
        init_eff[3] = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init_eff[4 + 2 * i] = key_reg[i][31:0];
            init_eff[5 + 2 * i] = key_reg[i][63:32];
        end
        init_eff[12] = ctr_eff;
        init_eff[13] = nonce_low_reg[31:0];
        init_eff[14] = nonce_low_reg[63:32];
        init_eff[15] = nonce_high_reg;
        init_cur     = init_eff;
        init_cur[12] = ctr_reg;
    end

    // four quarter rounds side by side, on columns or diagonals
    always_comb
    begin
        logic [1:0] lane;
        logic [3:0] ai, bi, ci, di;
        quad_t      q;
        work_rnd = work_reg;
        for (int i = 0; i < 4; i++)
        begin
            lane = 2'(i);
            ai   = {2'b00, lane};
            bi   = {2'b01, cmd.diag ? lane + 2'd1 : lane};
            ci   = {2'b10, cmd.diag ? lane + 2'd2 : lane};
            di   = {2'b11, cmd.diag ? lane + 2'd3 : lane};
            q    = qround(work_reg[ai], work_reg[bi], work_reg[ci], work_reg[di]);
            work_rnd[ai] = q.a;
            work_rnd[bi] = q.b;
            work_rnd[ci] = q.c;
            work_rnd[di] = q.d;
        end
    end

    assign ks_word = ks_reg[pos_reg];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            mask[8 * j +: 8] = (CNT_W'(j) < item_cnt_reg) ? 8'hff : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_A:      key_reg[0]     <= cfg_data;
                REG_KEY_B:      key_reg[1]     <= cfg_data;
                REG_KEY_C:      key_reg[2]     <= cfg_data;
                REG_KEY_D:      key_reg[3]     <= cfg_data;
                REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                REG_INIT_CTR:   init_ctr_reg   <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                ctr_reg <= ctr_eff;
                pos_reg <= pos_eff;
            end
            else if (cmd.add)
                ctr_reg <= ctr_reg + 32'd1;
            else if (cmd.emit)
                pos_reg <= pos_reg + 3'd1;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_data_reg <= data_in;
            item_cnt_reg  <= (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
            item_last_reg <= last_of_message;
        end
        if (cmd.load)
            work_reg <= init_eff;
        else if (cmd.round)
            work_reg <= work_rnd;
        if (cmd.add)
        begin
            for (int j = 0; j < 8; j++)
                ks_reg[j] <= {work_reg[2 * j + 1] + init_cur[2 * j + 1],
                              work_reg[2 * j] + init_cur[2 * j]};
        end
        if (cmd.emit)
        begin
            out_data_reg <= (item_data_reg ^ ks_word) & mask;
            out_cnt_reg  <= item_cnt_reg;
            out_last_reg <= item_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_out       = out_data_reg;
    assign byte_count_out = out_cnt_reg;
    assign last_out       = out_last_reg;

endmodule

// ===== sv/chacha20_stream_xor_top.sv =====
// Top level of the ChaCha20 stream XOR block: controller plus datapath.
// Depends on cc20_pkg, cc20_if, cc20_ctrl and cc20_datapath.
//
//   channel  | role   | payload
//   msg      | sink   | data_in, byte_count, first_of_message, last_of_message
//   res      | source | data_out, byte_count_out, last_out
//   cfg_*    | write  | cfg_index selects register, cfg_data holds value
//
// An item that opens a keystream block passes through accept, 20 rounds
// through one shared column/diagonal round unit, feed-forward add and emit;
// the other seven items of the block pass through accept and emit only.
// Reset clears configuration, block counter, position and result valid.
// A request is taken while a result waits; a stalled result holds emit.
module chacha20_stream_xor_top import cc20_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cc20_in_if.sink               msg,
    cc20_out_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    cc20_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_ready (msg.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cc20_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .data_in          (msg.data_in),
        .byte_count       (msg.byte_count),
        .first_of_message (msg.first_of_message),
        .last_of_message  (msg.last_of_message),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .data_out         (res.data_out),
        .byte_count_out   (res.byte_count_out),
        .last_out         (res.last_out)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for chacha20_stream_xor_top: drives message requests and register writes,
// predicts every result with an internal ChaCha20 keystream model and checks it field by field.
// Depends on cc20_pkg, cc20_if and the RTL of chacha20_stream_xor_top.
module tb;
    import cc20_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } cipher_result_t;

    class cipher_checker;
        logic [CFG_DATA_W-1:0] regs [7];
        word_t                 stream_words [16];
        word_t                 mix [16];
        word_t                 block_ctr;
        logic [2:0]            slot;
        cipher_result_t        expected_q [$];
        int                    fails;
        int                    results_checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (stream_words[i]) stream_words[i] = '0;
            block_ctr       = '0;
            slot            = '0;
            fails           = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_NONCE_HIGH || idx == REG_INIT_CTR)
                value[63:32] = '0;
            if (idx <= REG_INIT_CTR)
                regs[idx] = value;
        endfunction

        function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        function void refill(word_t ctr);
            word_t start [16];
            start[0]  = SIGMA0;
            start[1]  = SIGMA1;
            start[2]  = SIGMA2;
            start[3]  = SIGMA3;
            start[4]  = regs[REG_KEY_A][31:0];
            start[5]  = regs[REG_KEY_A][63:32];
            start[6]  = regs[REG_KEY_B][31:0];
            start[7]  = regs[REG_KEY_B][63:32];
            start[8]  = regs[REG_KEY_C][31:0];
            start[9]  = regs[REG_KEY_C][63:32];
            start[10] = regs[REG_KEY_D][31:0];
            start[11] = regs[REG_KEY_D][63:32];
            start[12] = ctr;
            start[13] = regs[REG_NONCE_LOW][31:0];
            start[14] = regs[REG_NONCE_LOW][63:32];
            start[15] = regs[REG_NONCE_HIGH][31:0];
            mix = start;
            repeat (10) begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++)
                stream_words[i] = mix[i] + start[i];
        endfunction

        function void note_request(logic [DATA_W-1:0] data, logic [CNT_W-1:0] count,
                                   logic first, logic last);
            cipher_result_t    r;
            logic [DATA_W-1:0] pad;
            logic [DATA_W-1:0] keep;
            logic [CNT_W-1:0]  n;
            if (first) begin
                block_ctr = regs[REG_INIT_CTR][31:0];
                slot      = '0;
            end
            n = (count > FULL_COUNT) ? FULL_COUNT : count;
            if (slot == 3'd0) begin
                refill(block_ctr);
                block_ctr++;
            end
            pad  = {stream_words[2 * slot + 1], stream_words[2 * slot]};
            slot = slot + 3'd1;
            keep = (n == FULL_COUNT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
            r.data  = (data ^ pad) & keep;
            r.count = n;
            r.last  = last;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [CNT_W-1:0] count,
                                   logic last);
            cipher_result_t want;
            results_checked++;
            if (expected_q.size() == 0) begin
                fails++;
                $display("%0t: result with no request pending, data_out %h", $time, data);
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data) begin
                fails++;
                $display("%0t: data_out expected %h actual %h", $time, want.data, data);
            end
            if (count !== want.count) begin
                fails++;
                $display("%0t: byte_count_out expected %0d actual %0d",
                         $time, want.count, count);
            end
            if (last !== want.last) begin
                fails++;
                $display("%0t: last_out expected %0b actual %0b", $time, want.last, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cc20_in_if  msg ();
    cc20_out_if res ();

    cipher_checker sb = new();
    int items_sent = 0;
    int quiet      = 0;

    chacha20_stream_xor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg.valid && msg.ready)
                sb.note_request(msg.data_in, msg.byte_count, msg.first_of_message,
                                msg.last_of_message);
            if (res.valid && res.ready)
                sb.check_result(res.data_out, res.byte_count_out, res.last_out);
        end
    end

    always @(posedge clk)
    begin
        if ((msg.valid && msg.ready) || (res.valid && res.ready) || cfg_we)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL chacha20_stream_xor_top");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off, and a stretch with none
    initial
    begin
        bit held;
        held = 1'b0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.results_checked >= 300)
            begin
                held = 1'b1;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (sb.results_checked >= 800 && sb.results_checked < 1000)
                res.ready <= 1'b1;
            else
                res.ready <= ($urandom_range(0, 99) >= 22);
        end
    end

    function automatic logic [DATA_W-1:0] random_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(logic [DATA_W-1:0] data, logic [CNT_W-1:0] count,
                             logic first, logic last);
        bit calm;
        calm = (items_sent >= 500 && items_sent < 700);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            msg.valid <= 1'b0;
            @(negedge clk);
        end
        msg.valid            <= 1'b1;
        msg.data_in          <= data;
        msg.byte_count       <= count;
        msg.first_of_message <= first;
        msg.last_of_message  <= last;
        do @(posedge clk); while (!msg.ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        msg.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(logic [63:0] ka, logic [63:0] kb, logic [63:0] kc,
                                  logic [63:0] kd, logic [63:0] nlo, logic [63:0] nhi,
                                  logic [63:0] ctr);
        set_reg(REG_KEY_A, ka);
        set_reg(REG_KEY_B, kb);
        set_reg(REG_KEY_C, kc);
        set_reg(REG_KEY_D, kd);
        set_reg(REG_NONCE_LOW, nlo);
        set_reg(REG_NONCE_HIGH, nhi);
        set_reg(REG_INIT_CTR, ctr);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_messages(int quota);
        int done;
        int len;
        done = 0;
        while (done < quota)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    send_item(random_payload(),
                              (k == len - 1) ? 4'($urandom_range(1, 8)) : FULL_COUNT,
                              k == 0, k == len - 1);
                done += len;
            end
            else
            begin
                send_item(random_payload(), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        msg.valid            = 1'b0;
        msg.data_in          = '0;
        msg.byte_count       = '0;
        msg.first_of_message = 1'b0;
        msg.last_of_message  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers still at reset; stream starts without a first flag
        send_item('1, FULL_COUNT, 1'b0, 1'b0);
        send_item('0, FULL_COUNT, 1'b0, 1'b0);
        send_item(random_payload(), 4'd3, 1'b0, 1'b0);
        send_item(random_payload(), 4'd0, 1'b0, 1'b0);
        send_item(random_payload(), 4'd15, 1'b0, 1'b0);
        send_item(random_payload(), 4'd9, 1'b0, 1'b1);
        send_item(random_payload(), FULL_COUNT, 1'b0, 1'b0);
        send_item(random_payload(), FULL_COUNT, 1'b0, 1'b0);
        send_item(random_payload(), 4'd5, 1'b0, 1'b0);
        send_item(random_payload(), 4'd1, 1'b1, 1'b1);
        drain();

        // all ones everywhere; counter wraps inside the message
        apply_settings('1, '1, '1, '1, '1, '1, '1);
        for (int k = 0; k < 10; k++)
            send_item(k[0] ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa,
                      (k == 9) ? 4'd7 : FULL_COUNT, k == 0, k == 9);
        send_item(random_payload(), FULL_COUNT, 1'b1, 1'b0);
        send_item(random_payload(), FULL_COUNT, 1'b1, 1'b0);
        send_item(random_payload(), 4'd2, 1'b0, 1'b1);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom});
                1: apply_settings('0, '0, '0, '0, '0, '0, '0);
                2: apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {32'h0, 32'hffff_ffff - $urandom_range(0, 3)});
                3: apply_settings(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                                  64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                                  64'h4a00_0000_0900_0000, 64'h0, 64'h1);
                default: apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                                        '1, {$urandom, $urandom},
                                        {$urandom, $urandom}, {$urandom, $urandom},
                                        {$urandom, $urandom});
            endcase
            run_messages(270);
            drain();
        end

        if (sb.fails == 0)
            $display("PASS chacha20_stream_xor_top");
        else
            $display("FAIL chacha20_stream_xor_top");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/cc20_pkg.sv
sv/cc20_if.sv
sv/cc20_ctrl.sv
sv/cc20_datapath.sv
sv/chacha20_stream_xor_top.sv
sim/tb.sv
